@@ rtl/pird_pkg.sv @@
// ----------------------------------------------------------------------------
// Pin IRQ registration and dispatch package
// Shared widths, codes, state encoding and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package pird_pkg;

    // Default geometry handed down from the top level.
    localparam int PORT_COUNT_DEF    = 5;
    localparam int PINS_PER_PORT_DEF = 32;

    // Fixed field widths of the transaction payloads.
    localparam int PORT_W  = 3;
    localparam int PIN_W   = 5;
    localparam int MODE_W  = 2;
    localparam int FLAGS_W = 32;
    localparam int CODE_W  = 4;

    // Operation codes.
    localparam logic OP_CONFIGURE = 1'b0;
    localparam logic OP_SERVICE   = 1'b1;

    // Edge modes.
    localparam logic [MODE_W-1:0] MODE_DISABLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RISING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FALLING = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH    = 2'd3;

    // Interrupt configuration codes.
    localparam logic [CODE_W-1:0] CODE_OFF     = 4'b0000;
    localparam logic [CODE_W-1:0] CODE_RISING  = 4'b1001;
    localparam logic [CODE_W-1:0] CODE_FALLING = 4'b1010;
    localparam logic [CODE_W-1:0] CODE_BOTH    = 4'b1011;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } pird_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic mem_rd;
        logic idx_inc;
        logic set_hit;
        logic append;
        logic shift_wr;
        logic len_dec;
        logic load_result;
    } pird_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op;
        logic mode_off;
        logic in_range;
        logic scan_end;
        logic match;
        logic full;
        logic out_free;
    } pird_status_t;

    // Maps an edge mode to its interrupt configuration code.
    function automatic logic [CODE_W-1:0] edge_code_of(input logic [MODE_W-1:0] m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_DISABLE: c = CODE_OFF;
            MODE_RISING:  c = CODE_RISING;
            MODE_FALLING: c = CODE_FALLING;
            default:      c = CODE_BOTH;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/pird_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pin IRQ registration and dispatch controller
// Sequences the list scan, the append, and the compaction after a removal.
// ----------------------------------------------------------------------------
module pird_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pird_pkg::pird_status_t status,
    output pird_pkg::pird_cmd_t    cmd
);
    import pird_pkg::*;

    pird_state_t state_reg;
    pird_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (!status.in_range || status.scan_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (!status.match)
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (status.op == OP_CONFIGURE && status.mode_off)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT_RD:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            ST_SCAN_RD:
            begin
                if (status.in_range && !status.scan_end)
                begin
                    cmd.mem_rd = 1'b1;
                end
                else if (status.in_range && status.op == OP_CONFIGURE &&
                         !status.mode_off && !status.full)
                begin
                    // Pin not listed yet and room left: put it at the tail.
                    cmd.append = 1'b1;
                end
            end
            ST_SCAN_CHK:
            begin
                if (status.match)
                begin
                    cmd.set_hit = 1'b1;
                end
                // On a removal the shift starts at the entry after the match.
                cmd.idx_inc = 1'b1;
            end
            ST_SHIFT_RD:
            begin
                if (status.scan_end)
                begin
                    cmd.len_dec = 1'b1;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_result = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/pird_datapath.sv @@
// ----------------------------------------------------------------------------
// Pin IRQ registration and dispatch datapath
// Holds the per-port pin lists, their lengths, the scan index and the result.
// ----------------------------------------------------------------------------
module pird_datapath #(
    parameter int PORT_COUNT    = pird_pkg::PORT_COUNT_DEF,
    parameter int PINS_PER_PORT = pird_pkg::PINS_PER_PORT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op,
    input  logic [pird_pkg::PORT_W-1:0]   port,
    input  logic [pird_pkg::PIN_W-1:0]    pin,
    input  logic [pird_pkg::MODE_W-1:0]   mode,
    input  logic [pird_pkg::FLAGS_W-1:0]  pending_flags,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [pird_pkg::CODE_W-1:0]   edge_code,
    output logic                          code_valid,
    output logic                          found,
    output logic [pird_pkg::PIN_W-1:0]    pending_pin,
    input  pird_pkg::pird_cmd_t           cmd,
    output pird_pkg::pird_status_t        status
);
    import pird_pkg::*;

    localparam int PW    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int IW    = (PINS_PER_PORT > 1) ? $clog2(PINS_PER_PORT) : 1;
    localparam int LW    = $clog2(PINS_PER_PORT + 1);
    localparam int AW    = PW + IW;
    localparam int DEPTH = 1 << AW;

    // Latched item.
    logic                op_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [PIN_W-1:0]    pin_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [FLAGS_W-1:0]  flags_reg;

    // Scan state.
    logic [LW-1:0]       idx_reg;
    logic                hit_reg;
    logic [PIN_W-1:0]    hit_pin_reg;
    logic [PIN_W-1:0]    rd_data_reg;

    // List storage.
    logic [LW-1:0]       len_reg [PORT_COUNT];
    logic [PIN_W-1:0]    mem [DEPTH];

    // Result register.
    logic                out_valid_reg;
    logic [CODE_W-1:0]   edge_code_reg;
    logic                code_valid_reg;
    logic                found_reg;
    logic [PIN_W-1:0]    pending_pin_reg;

    logic                port_ok;
    logic                pin_ok;
    logic [PW-1:0]       port_sel;
    logic [LW-1:0]       cur_len;
    logic [LW-1:0]       idx_m1;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;
    logic [PIN_W-1:0]    wr_data;

    // Range checks and the current port's length.
    assign port_ok  = ({1'b0, port_reg} < (PORT_W + 1)'(PORT_COUNT));
    assign pin_ok   = ({1'b0, pin_reg} < (PIN_W + 1)'(PINS_PER_PORT));
    assign port_sel = port_reg[PW-1:0];
    assign cur_len  = port_ok ? len_reg[port_sel] : '0;
    assign idx_m1   = idx_reg - LW'(1);

    // Memory addressing: one read port, one write port.
    assign rd_addr = {port_sel, idx_reg[IW-1:0]};
    assign wr_en   = cmd.append | cmd.shift_wr;
    assign wr_addr = cmd.append ? {port_sel, cur_len[IW-1:0]} : {port_sel, idx_m1[IW-1:0]};
    assign wr_data = cmd.append ? pin_reg : rd_data_reg;

    // Status toward the controller.
    always_comb
    begin
        status.op       = op_reg;
        status.mode_off = (mode_reg == MODE_DISABLE);
        status.in_range = port_ok && (op_reg == OP_SERVICE || pin_ok);
        status.scan_end = (idx_reg >= cur_len);
        status.match    = (op_reg == OP_SERVICE) ? flags_reg[rd_data_reg]
                                                 : (rd_data_reg == pin_reg);
        status.full     = (cur_len == LW'(PINS_PER_PORT));
        status.out_free = !out_valid_reg || !out_stall;
    end

    // Item capture, scan index and hit tracking.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= op;
            port_reg  <= port;
            pin_reg   <= pin;
            mode_reg  <= mode;
            flags_reg <= pending_flags;
        end
        if (cmd.load_item)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + LW'(1);
        end
        if (cmd.load_item)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.set_hit)
        begin
            hit_reg     <= 1'b1;
            hit_pin_reg <= rd_data_reg;
        end
    end

    // Pin list memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // List lengths.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (port_ok)
        begin
            if (cmd.append)
            begin
                len_reg[port_sel] <= cur_len + LW'(1);
            end
            else if (cmd.len_dec)
            begin
                len_reg[port_sel] <= cur_len - LW'(1);
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            if (op_reg == OP_CONFIGURE)
            begin
                edge_code_reg   <= edge_code_of(mode_reg);
                code_valid_reg  <= 1'b1;
                found_reg       <= 1'b0;
                pending_pin_reg <= '0;
            end
            else
            begin
                edge_code_reg   <= CODE_OFF;
                code_valid_reg  <= 1'b0;
                found_reg       <= hit_reg;
                pending_pin_reg <= hit_reg ? hit_pin_reg : '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign edge_code   = edge_code_reg;
    assign code_valid  = code_valid_reg;
    assign found       = found_reg;
    assign pending_pin = pending_pin_reg;

endmodule

@@ rtl/pin_irq_registration_dispatch.sv @@
// ----------------------------------------------------------------------------
// Pin IRQ registration and dispatch
// Keeps an ordered list of enabled pins per port and finds the pin to serve.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one transaction per item:
//   a configure (op 0) enables or disables a pin's interrupt and returns its
//   edge code; a service (op 1) brings a port's pending flags and returns the
//   first listed pin whose flag is set. Each item yields exactly one result
//   transaction on out_valid/out_stall.
//   Scan, with n the port's list length: each entry is read through the
//   single read port of the list memory and then checked. An item that
//   finds no hit walks the whole list; a service or an enable stops at
//   the first hit, in slot s; a disable that hits slot s moves the n - s - 1
//   entries behind it one slot lower, each read and then written.
//   Out-of-range items skip the scan. One item is in work at a time; the
//   next one is accepted once the current result is registered.
//   The result register is held while out_stall is high; a finished item
//   waits until the register is free, and the input stays stalled meanwhile.
//   Reset empties every list by clearing the list lengths.
// ----------------------------------------------------------------------------
module pin_irq_registration_dispatch #(
    parameter int PORT_COUNT    = pird_pkg::PORT_COUNT_DEF,
    parameter int PINS_PER_PORT = pird_pkg::PINS_PER_PORT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [pird_pkg::PORT_W-1:0]   port,
    input  logic [pird_pkg::PIN_W-1:0]    pin,
    input  logic [pird_pkg::MODE_W-1:0]   mode,
    input  logic [pird_pkg::FLAGS_W-1:0]  pending_flags,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pird_pkg::CODE_W-1:0]   edge_code,
    output logic                          code_valid,
    output logic                          found,
    output logic [pird_pkg::PIN_W-1:0]    pending_pin
);
    import pird_pkg::*;

    pird_cmd_t    cmd;
    pird_status_t status;

    // Sequencer.
    pird_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Lists, scan and result registers.
    pird_datapath #(
        .PORT_COUNT    (PORT_COUNT),
        .PINS_PER_PORT (PINS_PER_PORT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .port          (port),
        .pin           (pin),
        .mode          (mode),
        .pending_flags (pending_flags),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .edge_code     (edge_code),
        .code_valid    (code_valid),
        .found         (found),
        .pending_pin   (pending_pin),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
